// ===== hw/rtl/ufl_pkg.sv =====
// Package for the ultrasonic fill-level meter.
// Holds the field widths, counter widths and configuration register indexes.
// No dependencies.
package ufl_pkg;

  // Counter widths of the phase timer and the echo-width counter.
  localparam int unsigned ECHO_COUNT_BITS = 16;
  localparam int unsigned GAP_COUNT_BITS  = 20;

  // Configuration register widths.
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned TRIG_W = 10;
  localparam int unsigned GAP_W  = 20;
  localparam int unsigned THR_W  = 7;
  localparam int unsigned CFG_W  = 20;
  localparam int unsigned CFG_IDX_W = 2;

  // Result widths.
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned LAST_W = 8;

  // 58 * 1023 fits in 16 bits; 100 times that fits in 23 bits.
  localparam int unsigned FULL_W = 16;
  localparam int unsigned NUM_W  = FULL_W + 7;
  localparam int unsigned US_PER_CM = 58;
  localparam int unsigned PCT_SCALE = 100;

  // Width for comparing the phase timer against either length register.
  localparam int unsigned CMP_W = ((GAP_COUNT_BITS > GAP_W) ? GAP_COUNT_BITS : GAP_W) + 1;
  // Width for comparing the echo width against the full round-trip time.
  localparam int unsigned WCMP_W = (ECHO_COUNT_BITS > FULL_W) ? ECHO_COUNT_BITS : FULL_W;
  // Quotient bit counter.
  localparam int unsigned STEP_W = $clog2(PCT_W);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP          = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd3;

  // Reset values.
  localparam logic [LEN_W-1:0]  LEN_RESET  = 10'd30;
  localparam logic [TRIG_W-1:0] TRIG_RESET = 10'd10;
  localparam logic [GAP_W-1:0]  GAP_RESET  = 20'd100000;
  localparam logic [THR_W-1:0]  THR_RESET  = 7'd10;

endpackage

// ===== hw/rtl/ultrasonic_fill_level_meter.sv =====
// Ultrasonic fill-level meter: ranging sequencer with a shift-subtract divider.
// Depends on ufl_pkg.
//
// Each input item is one microsecond tick carrying the sampled echo level; each item gives
// exactly one result (trigger level, done flag, fill percent, change flag). A tick that does
// not end a measurement is accepted and its result is loaded into the output register at the
// same edge. The tick on which the echo falls is accepted and forms the numerator
// 100*(58*L - w); the compare-and-subtract unit then produces the seven quotient bits one at
// a time, and a final state compares the quotient with the last reported percent and loads
// the result. The input is ready again once the output register is free or being taken.
// The gap or trigger phase ends if its timer reaches 2^GAP_COUNT_BITS - 1, the echo counter
// saturates at 2^ECHO_COUNT_BITS - 1, and there is no echo timeout. Configuration is written
// through a plain write port whose data is masked to each register's width.
module ultrasonic_fill_level_meter
  import ufl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 echo_level_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 trigger_level_o,
  output logic                 sample_done_o,
  output logic [PCT_W-1:0]     fill_percent_o,
  output logic                 report_change_o
);

  typedef enum logic [1:0] {
    PH_GAP,
    PH_TRIG,
    PH_WAIT,
    PH_ECHO
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  // Configuration registers.
  logic [LEN_W-1:0]  len_q;
  logic [TRIG_W-1:0] trig_len_q;
  logic [GAP_W-1:0]  gap_len_q;
  logic [THR_W-1:0]  thr_q;

  // Sequencer and measurement state.
  state_e                     state_q;
  phase_e                     phase_q;
  logic [GAP_COUNT_BITS-1:0]  tick_q;
  logic [ECHO_COUNT_BITS-1:0] echo_w_q;
  logic signed [LAST_W-1:0]   last_q;
  logic [PCT_W-1:0]           cur_pct_q;

  // Divider datapath.
  logic [NUM_W-1:0]  rem_q;
  logic [NUM_W-1:0]  div_q;
  logic [PCT_W-1:0]  quo_q;
  logic [STEP_W-1:0] step_q;

  // Output register.
  logic             out_valid_q;
  logic             out_trig_q;
  logic             out_done_q;
  logic [PCT_W-1:0] out_pct_q;
  logic             out_rep_q;

  logic in_accept;
  logic out_free;

  // Phase timer.
  logic [CMP_W-1:0] phase_len;
  logic [CMP_W-1:0] tick_next;
  logic             tick_sat;
  logic             phase_end;

  // Percent setup.
  logic [FULL_W-1:0] full_len;
  logic              zero_case;
  logic [FULL_W-1:0] span;
  logic [NUM_W-1:0]  numer;
  logic [NUM_W-1:0]  divisor;

  // Divider step and change detection.
  logic              step_ge;
  logic signed [LAST_W:0] pct_diff;
  logic [LAST_W:0]   pct_abs;
  logic              report;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    phase_len = (phase_q == PH_GAP) ? CMP_W'(gap_len_q) : CMP_W'(trig_len_q);
    tick_next = CMP_W'(tick_q) + CMP_W'(1);
    tick_sat  = (tick_q == {GAP_COUNT_BITS{1'b1}});
    phase_end = tick_sat || (tick_next >= phase_len);
  end

  always_comb begin
    full_len  = FULL_W'({6'd0, len_q} * 16'(US_PER_CM));
    zero_case = (full_len == '0) || (WCMP_W'(echo_w_q) > WCMP_W'(full_len));
    span      = full_len - FULL_W'(echo_w_q);
    numer     = zero_case ? '0 : (NUM_W'(span) * NUM_W'(PCT_SCALE));
    // A zero numerator with a nonzero divisor yields a zero quotient.
    divisor   = zero_case ? NUM_W'(1) : NUM_W'(full_len);
  end

  always_comb begin
    step_ge  = (rem_q >= div_q);
    pct_diff = $signed({2'b00, quo_q}) - $signed({last_q[LAST_W-1], last_q});
    pct_abs  = pct_diff[LAST_W] ? (LAST_W + 1)'(-pct_diff) : pct_diff;
    report   = (pct_abs >= (LAST_W + 1)'(thr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= LEN_RESET;
      trig_len_q <= TRIG_RESET;
      gap_len_q  <= GAP_RESET;
      thr_q      <= THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TOTAL_LENGTH: len_q      <= cfg_data_i[LEN_W-1:0];
        CFG_TRIGGER:      trig_len_q <= cfg_data_i[TRIG_W-1:0];
        CFG_GAP:          gap_len_q  <= cfg_data_i[GAP_W-1:0];
        CFG_THRESHOLD:    thr_q      <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_GAP;
      tick_q      <= '0;
      echo_w_q    <= '0;
      last_q      <= '1;
      cur_pct_q   <= '0;
      out_valid_q <= 1'b0;
      out_trig_q  <= 1'b0;
      out_done_q  <= 1'b0;
      out_pct_q   <= '0;
      out_rep_q   <= 1'b0;
      rem_q       <= '0;
      div_q       <= '0;
      quo_q       <= '0;
      step_q      <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            // The falling tick leaves its result to the divider.
            out_valid_q <= (phase_q != PH_ECHO) || echo_level_i;
            out_trig_q  <= (phase_q == PH_TRIG);
            out_done_q  <= 1'b0;
            out_rep_q   <= 1'b0;
            out_pct_q   <= cur_pct_q;
            unique case (phase_q)
              PH_GAP, PH_TRIG: begin
                if (phase_end) begin
                  tick_q  <= '0;
                  phase_q <= (phase_q == PH_GAP) ? PH_TRIG : PH_WAIT;
                end else begin
                  tick_q <= tick_next[GAP_COUNT_BITS-1:0];
                end
              end
              PH_WAIT: begin
                if (echo_level_i) begin
                  echo_w_q <= ECHO_COUNT_BITS'(1);
                  phase_q  <= PH_ECHO;
                end
              end
              PH_ECHO: begin
                if (echo_level_i) begin
                  if (echo_w_q != {ECHO_COUNT_BITS{1'b1}}) begin
                    echo_w_q <= echo_w_q + ECHO_COUNT_BITS'(1);
                  end
                end else begin
                  // Echo fell: start the long division of the percent.
                  rem_q   <= numer;
                  div_q   <= divisor << (PCT_W - 1);
                  quo_q   <= '0;
                  step_q  <= '0;
                  state_q <= ST_DIV;
                end
              end
              default: ;
            endcase
          end else if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_DIV: begin
          if (step_ge) begin
            rem_q <= rem_q - div_q;
          end
          quo_q  <= {quo_q[PCT_W-2:0], step_ge};
          div_q  <= div_q >> 1;
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(PCT_W - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          cur_pct_q   <= quo_q;
          out_pct_q   <= quo_q;
          out_trig_q  <= 1'b0;
          out_done_q  <= 1'b1;
          out_rep_q   <= report;
          out_valid_q <= 1'b1;
          if (report) begin
            last_q <= $signed({1'b0, quo_q});
          end
          tick_q  <= '0;
          phase_q <= PH_GAP;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign trigger_level_o = out_trig_q;
  assign sample_done_o   = out_done_q;
  assign fill_percent_o  = out_pct_q;
  assign report_change_o = out_rep_q;

endmodule

// ===== tb/ufl_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the ultrasonic fill-level meter: follows the configuration writes, predicts
// one result for every accepted tick and compares it with the result items of the block.
// Depends on ufl_pkg.
module ufl_checker
  import ufl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 echo_level_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 trigger_level_i,
  input  logic                 sample_done_i,
  input  logic [PCT_W-1:0]     fill_percent_i,
  input  logic                 report_change_i,
  output int unsigned          pending_o,
  output int unsigned          errors_o
);

  typedef enum logic [1:0] {PH_GAP, PH_TRIG, PH_WAIT, PH_ECHO} meter_phase_e;

  typedef struct packed {
    logic             trigger;
    logic             done;
    logic [PCT_W-1:0] percent;
    logic             report;
  } tick_result_t;

  logic [LEN_W-1:0]  len_cfg;
  logic [TRIG_W-1:0] trig_cfg;
  logic [GAP_W-1:0]  gap_cfg;
  logic [THR_W-1:0]  thr_cfg;

  meter_phase_e                phase_q;
  logic [GAP_COUNT_BITS-1:0]   timer_q;
  logic [ECHO_COUNT_BITS-1:0]  echo_cnt_q;
  logic signed [LAST_W-1:0]    last_pct_q;
  logic [PCT_W-1:0]            pct_q;

  tick_result_t expected_results[$];
  int unsigned  mismatches = 0;

  // Advances the gap or trigger timer; returns 1 on the last tick of the phase.
  function automatic bit timer_step(input int unsigned len);
    int unsigned nxt;
    if (timer_q == '1) begin
      timer_q = '0;
      return 1'b1;
    end
    nxt = int'(timer_q) + 1;
    if (nxt >= len) begin
      timer_q = '0;
      return 1'b1;
    end
    timer_q = GAP_COUNT_BITS'(nxt);
    return 1'b0;
  endfunction

  function automatic logic [PCT_W-1:0] level_percent(input logic [ECHO_COUNT_BITS-1:0] w);
    int unsigned full;
    full = US_PER_CM * 32'(len_cfg);
    if (full == 0 || 32'(w) > full) return '0;
    return PCT_W'((PCT_SCALE * (full - 32'(w))) / full);
  endfunction

  function automatic tick_result_t predict_tick(input logic echo);
    tick_result_t r;
    int diff;
    r = '0;
    case (phase_q)
      PH_GAP: begin
        if (timer_step(32'(gap_cfg))) phase_q = PH_TRIG;
      end
      PH_TRIG: begin
        r.trigger = 1'b1;
        if (timer_step(32'(trig_cfg))) phase_q = PH_WAIT;
      end
      PH_WAIT: begin
        if (echo) begin
          echo_cnt_q = ECHO_COUNT_BITS'(1);
          phase_q = PH_ECHO;
        end
      end
      default: begin
        if (echo) begin
          if (echo_cnt_q != '1) echo_cnt_q++;
        end else begin
          pct_q = level_percent(echo_cnt_q);
          diff = int'(pct_q) - int'(last_pct_q);
          if (diff < 0) diff = -diff;
          if (diff >= int'(thr_cfg)) begin
            r.report = 1'b1;
            last_pct_q = LAST_W'(pct_q);
          end
          r.done = 1'b1;
          timer_q = '0;
          phase_q = PH_GAP;
        end
      end
    endcase
    r.percent = pct_q;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t want;
    if (!rst_ni) begin
      len_cfg    = LEN_RESET;
      trig_cfg   = TRIG_RESET;
      gap_cfg    = GAP_RESET;
      thr_cfg    = THR_RESET;
      phase_q    = PH_GAP;
      timer_q    = '0;
      echo_cnt_q = '0;
      last_pct_q = '1;
      pct_q      = '0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TOTAL_LENGTH: len_cfg  = cfg_data_i[LEN_W-1:0];
          CFG_TRIGGER:      trig_cfg = cfg_data_i[TRIG_W-1:0];
          CFG_GAP:          gap_cfg  = cfg_data_i[GAP_W-1:0];
          CFG_THRESHOLD:    thr_cfg  = cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      // The result of a tick accepted at this edge cannot leave at the same edge,
      // so outputs are matched before the new tick is predicted.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result item arrived with no tick outstanding", $time);
        end else begin
          want = expected_results.pop_front();
          check_field("trigger_level", 32'(want.trigger), 32'(trigger_level_i));
          check_field("sample_done", 32'(want.done), 32'(sample_done_i));
          check_field("fill_percent", 32'(want.percent), 32'(fill_percent_i));
          check_field("report_change", 32'(want.report), 32'(report_change_i));
        end
      end
      if (in_valid_i && in_ready_i) expected_results.push_back(predict_tick(echo_level_i));
    end
    pending_o <= expected_results.size();
    errors_o  <= mismatches;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the fill-level meter testbench: clock, reset, tick and configuration stimulus,
// and the verdict. Depends on ufl_pkg, ufl_checker and ultrasonic_fill_level_meter.
module tb_top;
  import ufl_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 echo_level_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 trigger_level_o;
  logic                 sample_done_o;
  logic [PCT_W-1:0]     fill_percent_o;
  logic                 report_change_o;

  int unsigned meter_pending;
  int unsigned meter_errors;

  int unsigned burst_left = 0;
  int unsigned ticks_sent = 0;
  int unsigned len_set, trig_set, gap_set;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always #5 clk_i = ~clk_i;

  ultrasonic_fill_level_meter dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .echo_level_i,
    .out_valid_o, .out_ready_i,
    .trigger_level_o, .sample_done_o, .fill_percent_o, .report_change_o
  );

  ufl_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .echo_level_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .trigger_level_i(trigger_level_o), .sample_done_i(sample_done_o),
    .fill_percent_i(fill_percent_o), .report_change_i(report_change_o),
    .pending_o(meter_pending), .errors_o(meter_errors)
  );

  // Receiver: switches between always ready, random, sparse and fully stalled stretches.
  always @(posedge clk_i) begin
    logic rdy;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(1, 40);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: rdy = 1'b1;
      1: rdy = 1'($urandom_range(0, 1));
      2: rdy = ($urandom_range(0, 3) == 0);
      default: rdy = 1'b0;
    endcase
    out_ready_i <= rdy;
  end

  // Sends one tick item; the sender runs in bursts separated by random gaps.
  task automatic send_tick(input logic echo);
    int unsigned idle;
    if (burst_left == 0) begin
      idle = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
      if (idle > 0) begin
        in_valid_i <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i   <= 1'b1;
    echo_level_i <= echo;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    ticks_sent++;
  endtask

  // Holds off the sender until every outstanding result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (meter_pending != 0);
    repeat (12) @(posedge clk_i);
  endtask

  // Unused upper data bits are filled with noise; the block must mask them off.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                           input int unsigned width);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(value) | (CFG_W'($urandom) << width);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned len, input int unsigned trig,
                           input int unsigned gap, input int unsigned thr);
    write_reg(CFG_TOTAL_LENGTH, len, LEN_W);
    write_reg(CFG_TRIGGER, trig, TRIG_W);
    write_reg(CFG_GAP, gap, GAP_W);
    write_reg(CFG_THRESHOLD, thr, THR_W);
    len_set  = len;
    trig_set = trig;
    gap_set  = gap;
  endtask

  // One ranging cycle: ignored noise through gap and trigger, a short wait with the echo
  // low, the echo held high for the given width, then the falling tick.
  task automatic measure(input int unsigned width, input bit noisy);
    int unsigned lead;
    int unsigned hold;
    lead = (gap_set == 0 ? 1 : gap_set) + (trig_set == 0 ? 1 : trig_set);
    hold = $urandom_range(0, 3);
    // Now and then the sequence is knocked out of step with the block.
    if (noisy && $urandom_range(0, 6) == 0) lead = lead - 1 + $urandom_range(0, 3);
    repeat (lead) send_tick(1'($urandom_range(0, 1)));
    repeat (hold) send_tick(noisy && $urandom_range(0, 7) == 0);
    repeat (width) send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic run_random_phase();
    int unsigned r;
    int unsigned full;
    int unsigned wmax;
    int unsigned w;
    drain();
    r = $urandom_range(0, 9);
    configure(r < 6 ? $urandom_range(1, 3) : (r < 7 ? 0 : $urandom_range(4, 1023)),
              $urandom_range(0, 4), $urandom_range(0, 5),
              $urandom_range(0, 9) == 0 ? $urandom_range(100, 127) : $urandom_range(0, 25));
    full = US_PER_CM * len_set;
    repeat ($urandom_range(2, 4)) begin
      if (full != 0 && full <= 200 && $urandom_range(0, 5) == 0) begin
        // Right around the point where the echo covers the whole length.
        w = full - 1 + $urandom_range(0, 2);
      end else begin
        wmax = (full == 0) ? 20 : ((full + 4 > 60) ? 60 : full + 4);
        w = $urandom_range(1, wmax);
      end
      measure(w, 1'b1);
    end
  endtask

  initial begin
    int unsigned start_ticks;
    len_set  = 32'(LEN_RESET);
    trig_set = 32'(TRIG_RESET);
    gap_set  = 32'(GAP_RESET);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a few ticks under the reset settings stay in the long gap.
    repeat (3) send_tick(1'b1);
    drain();
    // Zero gap and zero trigger still last one tick; a zero threshold reports every time.
    configure(1, 0, 0, 0);
    measure(1, 1'b0);
    measure(1, 1'b0);
    // Zero length gives zero percent; a threshold above 101 never reports.
    drain();
    configure(0, 1, 1, 127);
    measure(2, 1'b0);

    // Random phases with well-formed sequences and some noise.
    start_ticks = ticks_sent;
    while (ticks_sent - start_ticks < 300) run_random_phase();

    // Longest length with short echoes: the percent sits just under full.
    drain();
    configure(1023, 20, 1, 0);
    measure(3, 1'b0);
    measure(1, 1'b0);

    // Longest gap: the block only counts through the start of it.
    drain();
    configure(1023, 1023, 20'hFFFFF, 100);
    repeat (40) send_tick(1'($urandom_range(0, 1)));

    drain();
    repeat (20) @(posedge clk_i);
    if (meter_errors == 0 && meter_pending == 0) begin
      $display("[ultrasonic_fill_level_meter] OK");
    end else begin
      $display("[ultrasonic_fill_level_meter] ERROR");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("[ultrasonic_fill_level_meter] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ufl_pkg.sv
hw/rtl/ultrasonic_fill_level_meter.sv
tb/ufl_checker.sv
tb/tb_top.sv
